[design/emi2d_pkg.sv]
// Shared types, constants and saturating helpers for the 2D Euler motion integrator.
// No dependencies; used by every module of the block.
package emi2d_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MASS      = 3'd0;
    localparam logic [2:0] REG_INIT_SPD  = 3'd1;
    localparam logic [2:0] REG_MAX_SPD   = 3'd2;
    localparam logic [2:0] REG_FRICTION  = 3'd3;
    localparam logic [2:0] REG_GRAV_EN   = 3'd4;
    localparam logic [2:0] REG_GRAV_X    = 3'd5;
    localparam logic [2:0] REG_GRAV_Y    = 3'd6;

    localparam logic [30:0] MASS_RESET   = 31'd65536;
    // 0.1 in Q16.16 is 6554; squared in Q32.32
    localparam logic [63:0] SLOW_SPEED_SQ = 64'd42954916;
    localparam logic [63:0] SQRT_BIT_INIT = 64'h4000_0000_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV_AX, S_DIV_AY, S_DIV_FA, S_GRAV,
        S_SQ_VX, S_SQ_VY, S_NEAR, S_SQ_AX, S_SQ_AY, S_SUM_A, S_SQRT,
        S_MUL_XI, S_LAT_XI, S_DIV_VX, S_MUL_YI, S_LAT_YI, S_DIV_VY,
        S_DT_AX, S_DT_AY, S_ADD_VY, S_CLAMP, S_FRIC_M, S_FRIC,
        S_PX_M, S_PY_M, S_PY_ADD, S_DONE
    } emi2d_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } emi2d_div_req_t;

    typedef struct packed {
        logic        start;
        logic [63:0] rad;
    } emi2d_sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } emi2d_unit_rsp_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m;
    endfunction

    // Sign a magnitude and saturate to the signed 32 bit range
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
        logic signed [31:0] r;
        if (neg)
            r = (|m[63:31]) ? 32'sh8000_0000 : 32'(-$signed({1'b0, m[30:0]}));
        else
            r = (|m[63:31]) ? 32'sh7FFF_FFFF : $signed({1'b0, m[30:0]});
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
            r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

[design/euler_motion_integrator_2d_core.sv]
// Top level of the 2D semi-implicit Euler integrator: sequencer, shared 32x32
// multiplier, state and configuration registers. Uses emi2d_pkg, emi2d_div, emi2d_sqrt.
//
// Usage
//   Input channel (in_valid/in_stall) carries one request: force, step time,
//   ground flag and position. Output channel (out_valid/out_stall) returns one
//   result per request: new position and velocity. Velocity is kept inside.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   it only while no request is in flight.
// Timing
//   A request runs through a sequencer that drives one 32x32 multiplier (one
//   product a cycle, registered), a bit-serial divider and a bit-pair square
//   root. Three divisions are done for every request; a start from near rest
//   adds the root and two more divisions. One request is in flight at a time:
//   in_stall is high from the cycle after accept until the sequencer is back
//   in idle, so the next request can be taken in the same cycle that out_valid
//   rises.
// Reset
//   rst_n clears velocity to zero, mass to 1.0 and the other configuration registers and out_valid to 0.
// Back-pressure
//   The result sits in an output register; while out_stall is high it holds,
//   and a finished request waits in the sequencer until the register frees.
module euler_motion_integrator_2d_core
    import emi2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic [15:0]        step_time,
    input  logic               on_ground,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] vel_out_x,
    output logic signed [31:0] vel_out_y
);

    // configuration
    logic [30:0]        mass_reg, init_spd_reg, max_spd_reg, fric_reg;
    logic               grav_en_reg;
    logic signed [31:0] grav_x_reg, grav_y_reg;

    // velocity state
    logic signed [31:0] vx_reg, vy_reg;

    // latched request
    logic signed [31:0] fx_reg, fy_reg, px_reg, py_reg;
    logic [15:0]        dt_reg;
    logic               gnd_reg;

    // working values
    logic signed [31:0] ax_reg, ay_reg;
    logic [30:0]        fa_reg;
    logic [31:0]        len_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        prod_reg;
    logic               launch_reg, launch_next;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] opx_reg, opy_reg, ovx_reg, ovy_reg;

    emi2d_state_t       state_reg, state_next;

    logic [31:0]        mul_a, mul_b;
    emi2d_div_req_t     div_req;
    emi2d_sqrt_req_t    sqrt_req;
    emi2d_unit_rsp_t    div_rsp, sqrt_rsp;

    logic               accept;
    logic               out_free;
    logic [31:0]        eff_mass;
    logic [63:0]        a_sum;
    logic               slow;
    logic [31:0]        vx_mag;
    logic [31:0]        stepm;
    logic signed [31:0] vx_fric;
    logic               fric_on;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign eff_mass = (mass_reg == '0) ? 32'd1 : {1'b0, mass_reg};
    assign a_sum    = acc_reg + prod_reg;
    assign slow     = (a_sum < SLOW_SPEED_SQ) && ((ax_reg != '0) || (ay_reg != '0));
    assign vx_mag   = mag32(vx_reg);
    assign stepm    = prod_reg[47:16];
    assign fric_on  = (fx_reg == '0) && (fy_reg == '0) && (vx_reg != '0) && gnd_reg;

    always_comb
    begin
        if (vx_mag <= stepm)
            vx_fric = '0;
        else if (!vx_reg[31])
            vx_fric = vx_reg - $signed(stepm);
        else
            vx_fric = vx_reg + $signed(stepm);
    end

    emi2d_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    emi2d_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_DIV_AX;
            S_DIV_AX: if (div_rsp.done) state_next = S_DIV_AY;
            S_DIV_AY: if (div_rsp.done) state_next = S_DIV_FA;
            S_DIV_FA: if (div_rsp.done) state_next = S_GRAV;
            S_GRAV:   state_next = S_SQ_VX;
            S_SQ_VX:  state_next = S_SQ_VY;
            S_SQ_VY:  state_next = S_NEAR;
            S_NEAR:   state_next = slow ? S_SQ_AX : S_DT_AX;
            S_SQ_AX:  state_next = S_SQ_AY;
            S_SQ_AY:  state_next = S_SUM_A;
            S_SUM_A:  state_next = S_SQRT;
            S_SQRT:   if (sqrt_rsp.done) state_next = S_MUL_XI;
            S_MUL_XI: state_next = S_LAT_XI;
            S_LAT_XI: state_next = S_DIV_VX;
            S_DIV_VX: if (div_rsp.done) state_next = S_MUL_YI;
            S_MUL_YI: state_next = S_LAT_YI;
            S_LAT_YI: state_next = S_DIV_VY;
            S_DIV_VY: if (div_rsp.done) state_next = S_CLAMP;
            S_DT_AX:  state_next = S_DT_AY;
            S_DT_AY:  state_next = S_ADD_VY;
            S_ADD_VY: state_next = S_CLAMP;
            S_CLAMP:  state_next = S_FRIC_M;
            S_FRIC_M: state_next = S_FRIC;
            S_FRIC:   state_next = S_PX_M;
            S_PX_M:   state_next = S_PY_M;
            S_PY_M:   state_next = S_PY_ADD;
            S_PY_ADD: state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: unit operands and launches
    always_comb
    begin
        in_stall       = (state_reg != S_IDLE);
        mul_a          = '0;
        mul_b          = '0;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = eff_mass;
        sqrt_req.start = 1'b0;
        sqrt_req.rad   = acc_reg;
        launch_next    = launch_reg;
        case (state_reg)
            S_DIV_AX:
            begin
                div_req.start = !launch_reg;
                div_req.num   = {16'd0, mag32(fx_reg), 16'd0};
            end
            S_DIV_AY:
            begin
                div_req.start = !launch_reg;
                div_req.num   = {16'd0, mag32(fy_reg), 16'd0};
            end
            S_DIV_FA:
            begin
                div_req.start = !launch_reg;
                div_req.num   = {17'd0, fric_reg, 16'd0};
            end
            S_SQRT:     sqrt_req.start = !launch_reg;
            S_DIV_VX, S_DIV_VY:
            begin
                div_req.start = !launch_reg;
                div_req.num   = acc_reg;
                div_req.den   = len_reg;
            end
            S_SQ_VX:  begin mul_a = vx_mag;         mul_b = vx_mag;         end
            S_SQ_VY:  begin mul_a = mag32(vy_reg);  mul_b = mag32(vy_reg);  end
            S_SQ_AX:  begin mul_a = mag32(ax_reg);  mul_b = mag32(ax_reg);  end
            S_SQ_AY:  begin mul_a = mag32(ay_reg);  mul_b = mag32(ay_reg);  end
            S_MUL_XI: begin mul_a = mag32(ax_reg);  mul_b = {1'b0, init_spd_reg}; end
            S_MUL_YI: begin mul_a = mag32(ay_reg);  mul_b = {1'b0, init_spd_reg}; end
            S_DT_AX:  begin mul_a = mag32(ax_reg);  mul_b = {16'd0, dt_reg}; end
            S_DT_AY:  begin mul_a = mag32(ay_reg);  mul_b = {16'd0, dt_reg}; end
            S_FRIC_M: begin mul_a = {1'b0, fa_reg}; mul_b = {16'd0, dt_reg}; end
            S_PX_M:   begin mul_a = vx_mag;         mul_b = {16'd0, dt_reg}; end
            S_PY_M:   begin mul_a = mag32(vy_reg);  mul_b = {16'd0, dt_reg}; end
            default:  ;
        endcase
        if (div_req.start || sqrt_req.start)
            launch_next = 1'b1;
        else if (div_rsp.done || sqrt_rsp.done)
            launch_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            mass_reg      <= MASS_RESET;
            init_spd_reg  <= '0;
            max_spd_reg   <= '0;
            fric_reg      <= '0;
            grav_en_reg   <= 1'b0;
            grav_x_reg    <= '0;
            grav_y_reg    <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MASS:     mass_reg     <= cfg_data[30:0];
                    REG_INIT_SPD: init_spd_reg <= cfg_data[30:0];
                    REG_MAX_SPD:  max_spd_reg  <= cfg_data[30:0];
                    REG_FRICTION: fric_reg     <= cfg_data[30:0];
                    REG_GRAV_EN:  grav_en_reg  <= cfg_data[0];
                    REG_GRAV_X:   grav_x_reg   <= $signed(cfg_data);
                    REG_GRAV_Y:   grav_y_reg   <= $signed(cfg_data);
                    default:      ;
                endcase
            end

            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // velocity updates
            case (state_reg)
                S_DIV_VX:
                    if (div_rsp.done) vx_reg <= sat_mag(ax_reg[31], div_rsp.result);
                S_DIV_VY:
                    if (div_rsp.done) vy_reg <= sat_mag(ay_reg[31], div_rsp.result);
                S_DT_AY:
                    vx_reg <= sat_add(vx_reg, sat_mag(ax_reg[31], {16'd0, prod_reg[63:16]}));
                S_ADD_VY:
                    vy_reg <= sat_add(vy_reg, sat_mag(ay_reg[31], {16'd0, prod_reg[63:16]}));
                S_CLAMP:
                    if (vx_mag > {1'b0, max_spd_reg})
                        vx_reg <= vx_reg[31] ? -$signed({1'b0, max_spd_reg})
                                             : $signed({1'b0, max_spd_reg});
                S_FRIC:
                    if (fric_on) vx_reg <= vx_fric;
                default: ;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            fx_reg  <= force_x;
            fy_reg  <= force_y;
            dt_reg  <= step_time;
            gnd_reg <= on_ground;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
        end
        case (state_reg)
            S_DIV_AX: if (div_rsp.done) ax_reg <= sat_mag(fx_reg[31], div_rsp.result);
            S_DIV_AY: if (div_rsp.done) ay_reg <= sat_mag(fy_reg[31], div_rsp.result);
            S_DIV_FA:
                if (div_rsp.done)
                    fa_reg <= (|div_rsp.result[63:31]) ? 31'h7FFF_FFFF
                                                      : div_rsp.result[30:0];
            S_GRAV:
                if (grav_en_reg && !gnd_reg)
                begin
                    ax_reg <= sat_add(ax_reg, grav_x_reg);
                    ay_reg <= sat_add(ay_reg, grav_y_reg);
                end
            S_SQ_VY, S_SQ_AY, S_LAT_XI, S_LAT_YI: acc_reg <= prod_reg;
            S_SUM_A:  acc_reg <= a_sum;
            S_SQRT:
                if (sqrt_rsp.done)
                    len_reg <= (sqrt_rsp.result[31:0] == '0) ? 32'd1
                                                             : sqrt_rsp.result[31:0];
            S_PY_M:
                px_reg <= sat_add(px_reg, sat_mag(vx_reg[31], {16'd0, prod_reg[63:16]}));
            S_PY_ADD:
                py_reg <= sat_add(py_reg, sat_mag(vy_reg[31], {16'd0, prod_reg[63:16]}));
            default: ;
        endcase
        if (state_reg == S_DONE && out_free)
        begin
            opx_reg <= px_reg;
            opy_reg <= py_reg;
            ovx_reg <= vx_reg;
            ovy_reg <= vy_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_pos_x = opx_reg;
    assign new_pos_y = opy_reg;
    assign vel_out_x = ovx_reg;
    assign vel_out_y = ovy_reg;

    // a request, once taken, blocks the input on the next cycle
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall) else $error("input not blocked after accept");

    // divider finishes only while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_AX || state_reg == S_DIV_AY ||
                          state_reg == S_DIV_FA || state_reg == S_DIV_VX ||
                          state_reg == S_DIV_VY)) else $error("stray divider done");

    // root finishes only in its own step
    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_rsp.done |-> state_reg == S_SQRT) else $error("stray root done");

    // a held result is never overwritten by the sequencer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(vel_out_x) && $stable(new_pos_x))
        else $error("stalled result overwritten");

endmodule

[design/emi2d_div.sv]
// Restoring divider, one quotient bit per cycle: 64 bit dividend by 32 bit divisor.
// Depends on emi2d_pkg for the request and response structs.
module emi2d_div
    import emi2d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  emi2d_div_req_t  req,
    output emi2d_unit_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        shifted   = {rem_reg, num_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = req.num;
            quo_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[62:0], 1'b0};
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;

endmodule

[design/emi2d_sqrt.sv]
// Bit-pair integer square root of a 64 bit value, one result bit per cycle.
// Depends on emi2d_pkg for the request and response structs.
module emi2d_sqrt
    import emi2d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  emi2d_sqrt_req_t req,
    output emi2d_unit_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        trial     = r_reg + bit_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            x_next    = req.rad;
            r_next    = '0;
            bit_next  = SQRT_BIT_INIT;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = r_reg;

endmodule
